/* rtl/urf_pkg.sv */
// ----------------------------------------------------------------------------
// urf_pkg
// shared types, constants and byte selection for the record framer
// ----------------------------------------------------------------------------
package urf_pkg;

	localparam logic [7:0]  HDR_BYTE     = 8'h7E;
	localparam logic [7:0]  STX_BYTE     = 8'h5E;
	localparam logic [7:0]  END_BYTE     = 8'h23;
	localparam logic [7:0]  TRANS_BYTE   = 8'h03;
	localparam logic [7:0]  ONE_BYTE     = 8'h01;
	localparam logic [7:0]  ZERO_BYTE    = 8'h00;
	localparam logic [15:0] SEG_OVERHEAD = 16'd5;   // 1 + 2 + 2
	localparam logic [7:0]  DEV_TYPE_RST = 8'h01;

	// default depth of the command queue between front and back
	localparam int CMD_QUEUE_DEPTH = 4;

	// output sequence positions
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_HDR0     = 5'd0;
	localparam logic [STEP_W-1:0] STEP_STX      = 5'd1;
	localparam logic [STEP_W-1:0] STEP_PROTO    = 5'd2;
	localparam logic [STEP_W-1:0] STEP_DEV      = 5'd3;
	localparam logic [STEP_W-1:0] STEP_FIX0     = 5'd4;
	localparam logic [STEP_W-1:0] STEP_FIX1     = 5'd5;
	localparam logic [STEP_W-1:0] STEP_FIX2     = 5'd6;
	localparam logic [STEP_W-1:0] STEP_FIX3     = 5'd7;
	localparam logic [STEP_W-1:0] STEP_TRANS    = 5'd8;
	localparam logic [STEP_W-1:0] STEP_RSV0     = 5'd9;
	localparam logic [STEP_W-1:0] STEP_RSV1     = 5'd10;
	localparam logic [STEP_W-1:0] STEP_SEG_HI   = 5'd11;
	localparam logic [STEP_W-1:0] STEP_SEG_LO   = 5'd12;
	localparam logic [STEP_W-1:0] STEP_ADDR     = 5'd13;
	localparam logic [STEP_W-1:0] STEP_FGRP     = 5'd14;
	localparam logic [STEP_W-1:0] STEP_FITEM    = 5'd15;
	localparam logic [STEP_W-1:0] STEP_LEN_HI   = 5'd16;
	localparam logic [STEP_W-1:0] STEP_LEN_LO   = 5'd17;
	localparam logic [STEP_W-1:0] STEP_PAYLOAD  = 5'd18;
	localparam logic [STEP_W-1:0] STEP_SUM      = 5'd19;
	localparam logic [STEP_W-1:0] STEP_END      = 5'd20;

	// one classified item, front to back
	typedef struct packed {
		logic        first;      // opens a frame, header goes out first
		logic        len_zero;   // empty frame, no payload byte
		logic        close;      // checksum and end byte follow
		logic [7:0]  pbyte;
		logic [15:0] len;
		logic [7:0]  addr;
		logic [7:0]  fgrp;
		logic [7:0]  fitem;
		logic [7:0]  sum;        // final checksum, valid when close
	} cmd_t;

	function automatic logic [7:0] step_byte(input logic [STEP_W-1:0] step,
		input logic [7:0] dev_type, input cmd_t cmd);
		logic [15:0] seg;
		logic [7:0]  res;
		seg = cmd.len + SEG_OVERHEAD;
		unique case (step)
			STEP_HDR0:    res = HDR_BYTE;
			STEP_STX:     res = STX_BYTE;
			STEP_PROTO:   res = ONE_BYTE;
			STEP_DEV:     res = dev_type;
			STEP_FIX0, STEP_FIX1,
			STEP_FIX2, STEP_FIX3:  res = ONE_BYTE;
			STEP_TRANS:   res = TRANS_BYTE;
			STEP_RSV0, STEP_RSV1:  res = ZERO_BYTE;
			STEP_SEG_HI:  res = seg[15:8];
			STEP_SEG_LO:  res = seg[7:0];
			STEP_ADDR:    res = cmd.addr;
			STEP_FGRP:    res = cmd.fgrp;
			STEP_FITEM:   res = cmd.fitem;
			STEP_LEN_HI:  res = cmd.len[15:8];
			STEP_LEN_LO:  res = cmd.len[7:0];
			STEP_PAYLOAD: res = cmd.pbyte;
			STEP_SUM:     res = cmd.sum;
			STEP_END:     res = END_BYTE;
			default:      res = ZERO_BYTE;
		endcase
		return res;
	endfunction

endpackage

/* rtl/urf_front.sv */
// ----------------------------------------------------------------------------
// urf_front
// tracks frame position and checksum, classifies each accepted item
// ----------------------------------------------------------------------------
module urf_front
	import urf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] payload_length,
	input  logic [7:0]  slave_address,
	input  logic [7:0]  function_group,
	input  logic [7:0]  function_item,
	output cmd_t        cmd
);

	logic [15:0] bytes_left_q;
	logic [7:0]  sum_q;

	logic        is_first;
	logic        len_zero;
	logic [7:0]  base_sum;
	logic [7:0]  sum_cur;
	logic [7:0]  sum_new;
	logic [15:0] left_cur;
	logic [15:0] left_new;
	logic        close;

	always_comb begin
		is_first = (bytes_left_q == 16'd0);
		len_zero = is_first && (payload_length == 16'd0);
		base_sum = slave_address + function_group + function_item + payload_length[7:0];
		sum_cur  = is_first ? base_sum : sum_q;
		sum_new  = len_zero ? sum_cur : sum_cur + payload_byte;
		left_cur = is_first ? payload_length : bytes_left_q;
		left_new = len_zero ? 16'd0 : left_cur - 16'd1;
		close    = (left_new == 16'd0);

		cmd.first    = is_first;
		cmd.len_zero = len_zero;
		cmd.close    = close;
		cmd.pbyte    = payload_byte;
		cmd.len      = payload_length;
		cmd.addr     = slave_address;
		cmd.fgrp     = function_group;
		cmd.fitem    = function_item;
		cmd.sum      = sum_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 16'd0;
			sum_q        <= 8'd0;
		end else if (accept) begin
			bytes_left_q <= left_new;
			sum_q        <= close ? 8'd0 : sum_new;
		end
	end

endmodule

/* rtl/urf_queue.sv */
// ----------------------------------------------------------------------------
// urf_queue
// small command queue between front and back
// ----------------------------------------------------------------------------
module urf_queue
	import urf_pkg::*;
#(
	parameter int DEPTH = CMD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic nempty,
	output cmd_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign nempty  = (count_q != '0);
	assign rdata   = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && nempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/urf_back.sv */
// ----------------------------------------------------------------------------
// urf_back
// byte sequencer, emits header, payload, checksum and end byte
// ----------------------------------------------------------------------------
module urf_back
	import urf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] dev_type,
	input  logic       q_nempty,
	input  cmd_t       q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       frame_end
);

	logic              act_q;
	logic [STEP_W-1:0] step_q;
	cmd_t              cmd_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              frame_end_q;

	logic              adv;
	logic              emit;
	logic              done;
	logic [STEP_W-1:0] step_nxt;
	logic              load;

	always_comb begin
		adv      = !out_valid_q || !out_stall;
		emit     = act_q && adv;
		done     = 1'b0;
		step_nxt = step_q + STEP_W'(1);
		unique case (step_q)
			STEP_LEN_LO:  step_nxt = cmd_q.len_zero ? STEP_SUM : STEP_PAYLOAD;
			STEP_PAYLOAD: begin
				step_nxt = STEP_SUM;
				done     = !cmd_q.close;
			end
			STEP_END:     done = 1'b1;
			default:      step_nxt = step_q + STEP_W'(1);
		endcase
		load  = !act_q || (emit && done);
		q_pop = load && q_nempty;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (emit) begin
			out_byte_q  <= step_byte(step_q, dev_type, cmd_q);
			frame_end_q <= (step_q == STEP_END);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			step_q      <= STEP_HDR0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				act_q  <= 1'b1;
				step_q <= q_data.first ? STEP_HDR0 : STEP_PAYLOAD;
			end else if (emit && done) begin
				act_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_nxt;
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;

endmodule

/* rtl/udp_record_framer_top.sv */
// ----------------------------------------------------------------------------
// udp_record_framer_top
// frames records as byte streams: header, payload, checksum, end byte
// ----------------------------------------------------------------------------
//
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// input    | in_valid / in_stall    | payload_byte, payload_length,
//          |                        | slave_address, function_group, function_item
// output   | out_valid / out_stall  | out_byte, frame_end
// config   | cfg_we                 | cfg_wdata (device type byte)
//
// a payload item costs one output byte, a closing one two more (checksum, end);
// the first item of a frame costs 18 more bytes of header, so the input runs
// one item per cycle mid-frame and stalls on frame start once the queue fills
// the back sequencer emits one byte per cycle and sets the overall rate
// reset clears frame position, checksum, queue and sequencer; device type
// returns to 1
// in_stall is high only while the command queue is full; out_stall holds the
// output register and backs up the sequencer, then the queue, then the input
//
module udp_record_framer_top
	import urf_pkg::*;
#(
	parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] payload_length,
	input  logic [7:0]  slave_address,
	input  logic [7:0]  function_group,
	input  logic [7:0]  function_item,
	// output items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end
);

	logic [7:0] dev_type_q;   // header device type byte

	logic accept;             // input item taken this cycle
	logic q_full;
	logic q_nempty;
	logic q_pop;
	cmd_t front_cmd;          // classified item from the front
	cmd_t q_cmd;              // oldest queued item

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_type_q <= DEV_TYPE_RST;
		end else if (cfg_we) begin
			dev_type_q <= cfg_wdata;
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// front: frame position, checksum, item classification
	urf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.payload_byte   (payload_byte),
		.payload_length (payload_length),
		.slave_address  (slave_address),
		.function_group (function_group),
		.function_item  (function_item),
		.cmd            (front_cmd)
	);

	// queue lets front and back stall independently
	urf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.nempty (q_nempty),
		.rdata  (q_cmd)
	);

	// back: byte sequencer with registered output
	urf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dev_type  (dev_type_q),
		.q_nempty  (q_nempty),
		.q_data    (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

endmodule

/* sim/udp_record_framer_top_tb.sv */
// ----------------------------------------------------------------------------
// udp_record_framer_top_tb
// self-checking bench: random record frames in, framed byte stream checked out
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module udp_record_framer_top_tb;
	import urf_pkg::*;

	// one input item as the sender sees it
	typedef struct packed {
		logic [7:0]  pbyte;
		logic [15:0] len;
		logic [7:0]  addr;
		logic [7:0]  fgrp;
		logic [7:0]  fitem;
	} rec_item_t;

	// one output byte of a frame
	typedef struct packed {
		logic [7:0] value;
		logic       fend;
	} framed_byte_t;

	// receiver stall behavior, switched at random intervals
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_EVERY_THIRD,
		STALL_SPARSE
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	rec_item_t   drive_item = '0;
	logic [7:0]  payload_byte;
	logic [15:0] payload_length;
	logic [7:0]  slave_address;
	logic [7:0]  function_group;
	logic [7:0]  function_item;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_end;

	// sender side
	rec_item_t    pending_items[$];
	int           burst_left = 0;
	int           gap_left = 0;
	int           items_accepted = 0;
	int           frames_queued = 0;

	// predictor state, mirrors the block
	logic [7:0]   dev_type_shadow = DEV_TYPE_RST;
	logic [15:0]  open_bytes_left = '0;
	logic [7:0]   frame_checksum = '0;
	framed_byte_t expected_bytes[$];

	// receiver side
	stall_mode_t  stall_mode = STALL_NONE;
	int           stall_phase_left = 0;
	int           stall_tick = 0;
	logic         hold_off = 1'b0;
	int           bytes_checked = 0;
	int           mismatch_count = 0;
	logic [7:0]   last_dev_type;

	assign payload_byte   = drive_item.pbyte;
	assign payload_length = drive_item.len;
	assign slave_address  = drive_item.addr;
	assign function_group = drive_item.fgrp;
	assign function_item  = drive_item.fitem;

	udp_record_framer_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.payload_byte   (payload_byte),
		.payload_length (payload_length),
		.slave_address  (slave_address),
		.function_group (function_group),
		.function_item  (function_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.frame_end      (frame_end)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// mismatch reporting, one line each
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// frame predictor
	// ------------------------------------------------------------------
	function automatic void push_byte(input logic [7:0] value, input logic fend);
		framed_byte_t fb;
		fb.value = value;
		fb.fend  = fend;
		expected_bytes.push_back(fb);
	endfunction

	// checksum then end byte, frame closes
	function automatic void close_frame();
		push_byte(frame_checksum, 1'b0);
		push_byte(END_BYTE, 1'b1);
		frame_checksum  = '0;
		open_bytes_left = '0;
	endfunction

	// expected bytes caused by one accepted item
	function automatic void frame_predict(input rec_item_t it);
		logic [15:0] seg_len;
		if (open_bytes_left == 16'd0) begin
			// first item of a frame: header fields sampled here only
			seg_len = it.len + SEG_OVERHEAD;   // wraps for lengths near the top
			push_byte(HDR_BYTE, 1'b0);
			push_byte(STX_BYTE, 1'b0);
			push_byte(ONE_BYTE, 1'b0);
			push_byte(dev_type_shadow, 1'b0);
			repeat (4) push_byte(ONE_BYTE, 1'b0);
			push_byte(TRANS_BYTE, 1'b0);
			push_byte(ZERO_BYTE, 1'b0);
			push_byte(ZERO_BYTE, 1'b0);
			push_byte(seg_len[15:8], 1'b0);
			push_byte(seg_len[7:0], 1'b0);
			push_byte(it.addr, 1'b0);
			push_byte(it.fgrp, 1'b0);
			push_byte(it.fitem, 1'b0);
			push_byte(it.len[15:8], 1'b0);
			push_byte(it.len[7:0], 1'b0);
			frame_checksum = it.addr + it.fgrp + it.fitem + it.len[7:0];
			if (it.len == 16'd0) begin
				// empty frame, the payload byte is dropped
				close_frame();
				return;
			end
			open_bytes_left = it.len;
		end
		push_byte(it.pbyte, 1'b0);
		frame_checksum  = frame_checksum + it.pbyte;
		open_bytes_left = open_bytes_left - 16'd1;
		if (open_bytes_left == 16'd0)
			close_frame();
	endfunction

	// ------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------
	// one whole frame; later items carry random header fields that must be ignored
	function automatic void queue_frame(input logic [15:0] len, input logic [7:0] addr,
		input logic [7:0] fgrp, input logic [7:0] fitem, input logic [7:0] first_byte);
		rec_item_t it;
		int        n_items;
		it.pbyte = first_byte;
		it.len   = len;
		it.addr  = addr;
		it.fgrp  = fgrp;
		it.fitem = fitem;
		pending_items.push_back(it);
		frames_queued++;
		n_items = (len == 16'd0) ? 1 : int'(len);
		for (int i = 1; i < n_items; i++) begin
			it.pbyte = 8'($urandom_range(0, 255));
			it.len   = 16'($urandom_range(0, 65535));
			it.addr  = 8'($urandom_range(0, 255));
			it.fgrp  = 8'($urandom_range(0, 255));
			it.fitem = 8'($urandom_range(0, 255));
			pending_items.push_back(it);
		end
	endfunction

	// mostly short frames, some empty ones, a few longer
	function automatic void queue_random_frames(input int item_budget);
		int added;
		int len;
		int pick;
		added = 0;
		while (added < item_budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				len = 0;
			else if (pick < 65)
				len = $urandom_range(1, 4);
			else if (pick < 93)
				len = $urandom_range(5, 12);
			else
				len = $urandom_range(20, 40);
			queue_frame(len[15:0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			added += (len == 0) ? 1 : len;
		end
	endfunction

	// wait until every queued item went in and every predicted byte came out
	task automatic wait_until_drained();
		int guard;
		guard = 0;
		while ((pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
			&& guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_bytes.size() != 0) begin
			report_mismatch($sformatf("%0d expected bytes never delivered",
				expected_bytes.size()));
			expected_bytes.delete();
		end
		// let the sequencer settle before touching the register
		repeat (8) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_device_type(input logic [7:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		dev_type_shadow = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// item driver: bursts of random length, random gaps between bursts
	// ------------------------------------------------------------------
	always @(posedge clk) begin : item_driver
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				frame_predict(drive_item);
				items_accepted++;
			end
			// a stalled item holds its payload
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					drive_item <= pending_items.pop_front();
					in_valid   <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						// about a quarter of the bursts run straight into the next
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// byte monitor and receiver stall pattern
	// ------------------------------------------------------------------
	always @(posedge clk) begin : byte_monitor
		framed_byte_t want;
		logic         stall_next;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				bytes_checked++;
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h end %0b with nothing expected",
						out_byte, frame_end));
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value)
						report_mismatch($sformatf("byte %0d: out_byte %02h expected %02h",
							bytes_checked, out_byte, want.value));
					if (frame_end !== want.fend)
						report_mismatch($sformatf("byte %0d: frame_end %b expected %b",
							bytes_checked, frame_end, want.fend));
				end
			end
			// switch stall behavior at random intervals
			if (stall_phase_left == 0) begin
				stall_mode       = stall_mode_t'($urandom_range(0, 3));
				stall_phase_left = $urandom_range(16, 160);
			end else begin
				stall_phase_left--;
			end
			stall_tick++;
			case (stall_mode)
				STALL_NONE:        stall_next = 1'b0;
				STALL_COIN:        stall_next = 1'($urandom_range(0, 1));
				STALL_EVERY_THIRD: stall_next = (stall_tick % 3) == 0;
				default:           stall_next = $urandom_range(0, 7) == 0;
			endcase
			out_stall <= hold_off || stall_next;
		end
	end

	// long receiver hold-off in the middle of the random frames, so the queue
	// fills and the input gets stalled while the sender keeps offering items
	initial begin : long_hold_off
		wait (items_accepted >= 40);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ------------------------------------------------------------------
	// run sequence
	// ------------------------------------------------------------------
	initial begin : run_sequence
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset device type
		queue_frame(16'd0, 8'h5a, 8'h11, 8'h22, 8'hff);      // empty frame
		queue_frame(16'd1, 8'hff, 8'hff, 8'hff, 8'hff);      // all-ones fields
		queue_frame(16'd1, 8'h00, 8'h00, 8'h00, 8'h00);      // all-zeros fields
		queue_frame(16'd3, 8'h80, 8'h7f, 8'h01, 8'h40);      // mid-frame fields ignored
		queue_frame(16'd2, 8'hc3, 8'hf0, 8'h0f, 8'haa);      // checksum wraps
		queue_frame(16'd0, 8'h00, 8'h00, 8'h00, 8'h00);      // empty again, back to back
		wait_until_drained();

		// device type at zero, then a longer frame streaming mid-frame items
		write_device_type(8'h00);
		queue_frame(16'd24, 8'ha5, 8'h5a, 8'h3c, 8'hc3);
		wait_until_drained();

		// random frames at the top device type
		write_device_type(8'hff);
		queue_random_frames(45);
		wait_until_drained();

		// random frames at a random device type
		last_dev_type = 8'($urandom_range(0, 255));
		write_device_type(last_dev_type);
		queue_random_frames(45);
		wait_until_drained();

		$display("run covered %0d items in %0d frames and %0d checked output bytes",
			items_accepted, frames_queued, bytes_checked);
		$display("device types 01, 00, ff and %02h; empty, single-byte and longer frames",
			last_dev_type);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hard stop far beyond the slowest legal run
	initial begin : run_limit
		#30ms;
		$display("timeout after %0d items and %0d bytes", items_accepted, bytes_checked);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
